// ===== src/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants for the epoch-to-calendar converter
// Unit lengths in seconds, month lengths and the subtract unit's result type.
// ----------------------------------------------------------------------------
`default_nettype none

package epc_pkg;

   localparam int unsigned OPER_W = 32;

   localparam logic [OPER_W-1:0] DAY_SECS       = 32'd86400;
   localparam logic [OPER_W-1:0] HOUR_SECS      = 32'd3600;
   localparam logic [OPER_W-1:0] MINUTE_SECS    = 32'd60;
   localparam logic [OPER_W-1:0] YEAR_SECS      = 32'd31536000;
   localparam logic [OPER_W-1:0] LEAP_YEAR_SECS = 32'd31622400;
   localparam logic [OPER_W-1:0] FEB_SECS       = 32'd2419200;
   localparam logic [OPER_W-1:0] FEB_LEAP_SECS  = 32'd2505600;
   localparam logic [OPER_W-1:0] MONTH_30_SECS  = 32'd2592000;
   localparam logic [OPER_W-1:0] MONTH_31_SECS  = 32'd2678400;

   localparam logic [11:0] BASE_YEAR    = 12'd1970;
   localparam logic [1:0]  BASE_MOD4    = 2'd2;
   localparam logic [6:0]  BASE_MOD100  = 7'd70;
   localparam logic [8:0]  BASE_MOD400  = 9'd370;
   localparam logic [3:0]  LAST_MONTH   = 4'd11;

   typedef struct packed {
      logic              ge;
      logic [OPER_W-1:0] diff;
   } sub_result_type;

   // month length in seconds, month 0 is January
   function automatic logic [OPER_W-1:0] month_secs(input logic leap, input logic [3:0] mon);
      logic [OPER_W-1:0] len;
      case (mon) inside
         4'd1:                    len = leap ? FEB_LEAP_SECS : FEB_SECS;
         4'd3, 4'd5, 4'd8, 4'd10: len = MONTH_30_SECS;
         default:                 len = MONTH_31_SECS;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== src/epc_sub_unit.sv =====
// ----------------------------------------------------------------------------
// epc_sub_unit: shared compare-and-subtract unit
// Gives minuend minus subtrahend and whether the minuend is not below it.
// ----------------------------------------------------------------------------
`default_nettype none

module epc_sub_unit (
   input  wire logic [epc_pkg::OPER_W-1:0] minuend,
   input  wire logic [epc_pkg::OPER_W-1:0] subtrahend,
   output epc_pkg::sub_result_type         result
);

   logic [epc_pkg::OPER_W:0] wide;

   assign wide        = {1'b0, minuend} - {1'b0, subtrahend};
   assign result.ge   = ~wide[epc_pkg::OPER_W];
   assign result.diff = wide[epc_pkg::OPER_W-1:0];

endmodule

`default_nettype wire

// ===== src/epoch_seconds_to_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: seconds since 1970 UTC to calendar date/time
// Each item steps through the year, month, day, hour and minute states: one subtract per
// year, month, day, hour and minute removed plus one closing compare per unit,
// all through the single compare-and-subtract unit. One item at a time: the
// next item is taken the cycle after the result is registered.
// Synchronous reset clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata    // [11:0] year, [15:12] month, [20:16] day,
                                         // [25:21] hour, [31:26] minute,
                                         // [37:32] second, [39:38] zero
);

   typedef enum logic [2:0] {
      S_IDLE, S_YEAR, S_MONTH, S_DAY, S_HOUR, S_MIN, S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] work_ff, work_in;
   logic [11:0] year_ff, year_in;
   logic [1:0]  mod4_ff, mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic [epc_pkg::OPER_W-1:0] op_b;
   epc_pkg::sub_result_type    sub_res;
   logic                       leap;
   logic [4:0]                 day_num;

   assign leap = (mod4_ff == 2'd0 && mod100_ff != 7'd0) || (mod400_ff == 9'd0);

   epc_sub_unit u_sub (
      .minuend    (work_ff),
      .subtrahend (op_b),
      .result     (sub_res)
   );

   always_comb begin
      op_b = epc_pkg::DAY_SECS;
      unique case (state_ff)
         S_YEAR: begin
            op_b = leap ? epc_pkg::LEAP_YEAR_SECS : epc_pkg::YEAR_SECS;
         end
         S_MONTH: begin
            op_b = epc_pkg::month_secs(leap, mon_ff);
         end
         S_HOUR: begin
            op_b = epc_pkg::HOUR_SECS;
         end
         S_MIN: begin
            op_b = epc_pkg::MINUTE_SECS;
         end
         default: begin
            op_b = epc_pkg::DAY_SECS;
         end
      endcase
   end

   assign day_num = day_ff + 5'd1;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      year_in      = year_ff;
      mod4_in      = mod4_ff;
      mod100_in    = mod100_ff;
      mod400_in    = mod400_ff;
      mon_in       = mon_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               work_in   = req_tdata;
               year_in   = epc_pkg::BASE_YEAR;
               mod4_in   = epc_pkg::BASE_MOD4;
               mod100_in = epc_pkg::BASE_MOD100;
               mod400_in = epc_pkg::BASE_MOD400;
               mon_in    = 4'd0;
               day_in    = 5'd0;
               hour_in   = 5'd0;
               min_in    = 6'd0;
               state_in  = S_YEAR;
            end
         end
         S_YEAR: begin
            if (sub_res.ge) begin
               work_in   = sub_res.diff;
               year_in   = year_ff + 12'd1;
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
            end else begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            if (mon_ff != epc_pkg::LAST_MONTH && sub_res.ge) begin
               work_in = sub_res.diff;
               mon_in  = mon_ff + 4'd1;
            end else begin
               state_in = S_DAY;
            end
         end
         S_DAY: begin
            if (sub_res.ge) begin
               work_in = sub_res.diff;
               day_in  = day_ff + 5'd1;
            end else begin
               state_in = S_HOUR;
            end
         end
         S_HOUR: begin
            if (sub_res.ge) begin
               work_in = sub_res.diff;
               hour_in = hour_ff + 5'd1;
            end else begin
               state_in = S_MIN;
            end
         end
         S_MIN: begin
            if (sub_res.ge) begin
               work_in = sub_res.diff;
               min_in  = min_ff + 6'd1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, work_ff[5:0], min_ff, hour_ff, day_num,
                               mon_ff + 4'd1, year_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff     <= work_in;
      year_ff     <= year_in;
      mod4_ff     <= mod4_in;
      mod100_ff   <= mod100_in;
      mod400_ff   <= mod400_in;
      mon_ff      <= mon_in;
      day_ff      <= day_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted item did not start conversion");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] != 4'd0 && rsp_tdata[15:12] <= 4'd12)
      else $error("month out of range");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:21] < 5'd24 && rsp_tdata[31:26] < 6'd60
                     && rsp_tdata[37:32] < 6'd60)
      else $error("time of day out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_YEAR |-> year_ff <= 12'd2106)
      else $error("year count ran past range");

   a_work_below_day: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOUR |-> work_ff < epc_pkg::DAY_SECS)
      else $error("time of day remainder not below one day");

endmodule

`default_nettype wire

// ===== tb/epoch_seconds_to_calendar_unit_tb.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit_tb: self-checking bench for the converter
// A directed table (epoch origin, unit edges, leap days, century rule, top of
// range) followed by biased random seconds. Each accepted item without a typed
// directed row is converted by a local calendar predictor; every result is compared field by field.
// Both stream sides idle at random; one long output hold and one full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_unit_tb;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned EPOCH_YEAR    = 1970;
   localparam int unsigned LAST_DAY_IDX  = 49710;

   localparam int N_DIRECTED       = 20;
   localparam int RANDOM_ITEMS     = 1380;
   localparam int LONG_HOLD_AT     = 200;
   localparam int LONG_HOLD_CYCLES = 800;
   localparam int DRAIN_PAUSE_AT   = 900;
   localparam int BURST_FIRST      = 500;
   localparam int BURST_LAST       = 650;
   localparam int TAIL_CYCLES      = 300;

   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // matches the rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [1:0]  pad;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } calendar_type;

   typedef struct packed {
      logic [31:0]  secs;
      logic         typed;
      calendar_type date;
   } stim_row_type;

   // typed rows: pad, second, minute, hour, day, month, year
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{32'd0,          1'b1, '{2'd0, 6'd0,  6'd0,  5'd0, 5'd1, 4'd1, 12'd1970}},
      '{32'd1,          1'b0, '0},
      '{32'd59,         1'b1, '{2'd0, 6'd59, 6'd0,  5'd0, 5'd1, 4'd1, 12'd1970}},
      '{32'd60,         1'b1, '{2'd0, 6'd0,  6'd1,  5'd0, 5'd1, 4'd1, 12'd1970}},
      '{32'd3599,       1'b0, '0},
      '{32'd3600,       1'b1, '{2'd0, 6'd0,  6'd0,  5'd1, 5'd1, 4'd1, 12'd1970}},
      '{32'd86399,      1'b0, '0},
      '{32'd86400,      1'b1, '{2'd0, 6'd0,  6'd0,  5'd0, 5'd2, 4'd1, 12'd1970}},
      '{32'd2678400,    1'b0, '0},
      '{32'd31535999,   1'b0, '0},
      '{32'd31536000,   1'b0, '0},
      '{32'd68169600,   1'b0, '0},
      '{32'd951782400,  1'b0, '0},
      '{32'd951868800,  1'b0, '0},
      '{32'd4107456000, 1'b0, '0},
      '{32'd4107542400, 1'b0, '0},
      '{32'h7FFF_FFFF,  1'b0, '0},
      '{32'h8000_0000,  1'b0, '0},
      '{32'hAAAA_AAAA,  1'b0, '0},
      '{32'hFFFF_FFFF,  1'b1, '{2'd0, 6'd15, 6'd28, 5'd6, 5'd7, 4'd2, 12'd2106}}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] epoch_seconds
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [11:0] year, [15:12] month, [20:16] day,
                                   // [25:21] hour, [31:26] minute, [37:32] second

   calendar_type expected_dates [$];
   int           mismatch_count = 0;

   epoch_seconds_to_calendar_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic bit is_leap_year(input int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function automatic calendar_type civil_from_epoch(input logic [31:0] secs);
      calendar_type cal;
      int unsigned  total;
      int unsigned  day_count;
      int unsigned  sod;
      int unsigned  yr;
      int unsigned  mo;
      int unsigned  span;
      bit           leap;
      total     = secs;
      day_count = total / SECS_PER_DAY;
      sod       = total % SECS_PER_DAY;
      yr        = EPOCH_YEAR;
      span      = is_leap_year(yr) ? 366 : 365;
      while (day_count >= span) begin
         day_count -= span;
         yr++;
         span = is_leap_year(yr) ? 366 : 365;
      end
      leap = is_leap_year(yr);
      mo   = 0;
      span = MONTH_DAYS[0];
      while (mo < 11 && day_count >= span) begin
         day_count -= span;
         mo++;
         span = MONTH_DAYS[mo] + ((leap && mo == 1) ? 1 : 0);
      end
      cal.pad    = '0;
      cal.year   = yr[11:0];
      cal.month  = 4'(mo + 1);
      cal.day    = 5'(day_count + 1);
      cal.hour   = 5'(sod / SECS_PER_HOUR);
      cal.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
      cal.second = 6'(sod % SECS_PER_MIN);
      return cal;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(30_000_000);
      $display("FAIL");
      $finish;
   end

   initial begin : sender
      int               k;
      int               gap;
      int unsigned      day_idx;
      longint unsigned  wide;
      logic [31:0]      secs;
      while (reset) @(posedge clock);
      for (k = 0; k < N_DIRECTED + RANDOM_ITEMS; k++) begin
         if (k < N_DIRECTED) begin
            secs = DIRECTED_ROWS[k].secs;
         end else begin
            day_idx = $urandom_range(LAST_DAY_IDX);
            wide    = longint'(day_idx) * SECS_PER_DAY;
            case ($urandom_range(3))
               0: secs = $urandom;
               1: begin
                  case ($urandom_range(3))
                     0: wide += 0;
                     1: wide += 1;
                     2: wide += SECS_PER_DAY - 1;
                     default: wide += $urandom_range(SECS_PER_DAY - 1);
                  endcase
                  secs = (wide > 64'hFFFF_FFFF) ? $urandom : wide[31:0];
               end
               2: secs = (day_idx == 0) ? 32'd0 : 32'(wide - 1);
               default: begin
                  secs = $urandom_range(100_000_000);
                  if ($urandom_range(1)) secs = 32'hFFFF_FFFF - secs;
               end
            endcase
         end
         gap = (k >= BURST_FIRST && k < BURST_LAST) ? 0 : $urandom_range(10);
         if (k == DRAIN_PAUSE_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_dates.size() != 0);
         end else if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= secs;
         do @(posedge clock); while (!req_tready);
         if (k < N_DIRECTED && DIRECTED_ROWS[k].typed)
            expected_dates.push_back(DIRECTED_ROWS[k].date);
         else
            expected_dates.push_back(civil_from_epoch(secs));
      end
      req_tvalid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : receiver
      int           got;
      int           stall;
      int           i;
      calendar_type want;
      calendar_type seen;
      got = 0;
      while (reset) @(posedge clock);
      forever begin
         if (got == LONG_HOLD_AT) begin
            rsp_tready <= 1'b0;
            for (i = 0; i < LONG_HOLD_CYCLES; i++) @(posedge clock);
         end else begin
            stall = (got >= BURST_FIRST && got < BURST_LAST) ? 0 : $urandom_range(10);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               // half the time the hold starts once the result is on offer
               if ($urandom_range(1)) begin
                  do @(posedge clock); while (!rsp_tvalid);
               end
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got++;
         seen = rsp_tdata;
         if (expected_dates.size() == 0) begin
            $error("unexpected item: rsp_tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_dates.pop_front();
            if (seen.year != want.year) begin
               $error("year: expected %0d, actual %0d", want.year, seen.year);
               mismatch_count++;
            end
            if (seen.month != want.month) begin
               $error("month: expected %0d, actual %0d", want.month, seen.month);
               mismatch_count++;
            end
            if (seen.day != want.day) begin
               $error("day: expected %0d, actual %0d", want.day, seen.day);
               mismatch_count++;
            end
            if (seen.hour != want.hour) begin
               $error("hour: expected %0d, actual %0d", want.hour, seen.hour);
               mismatch_count++;
            end
            if (seen.minute != want.minute) begin
               $error("minute: expected %0d, actual %0d", want.minute, seen.minute);
               mismatch_count++;
            end
            if (seen.second != want.second) begin
               $error("second: expected %0d, actual %0d", want.second, seen.second);
               mismatch_count++;
            end
            if (seen.pad != want.pad) begin
               $error("pad: expected %0d, actual %0d", want.pad, seen.pad);
               mismatch_count++;
            end
         end
      end
   end

endmodule

`default_nettype wire
